### sv/scab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scab_pkg: shared types and constants of the same-size convolution block
// Word layouts, op codes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package scab_pkg;

  localparam int SAMP_W = 16;   // Q1.15 tap and sample width
  localparam int RES_W  = 38;   // Q8.30 result width
  localparam int IDX_W  = 16;   // destination index width
  localparam int CNT_W  = 17;   // pushed item count width
  localparam int TIDX_W = 6;    // tap index field width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Reset values of the registers
  localparam logic [6:0]  TAP_COUNT_RST  = 7'd1;
  localparam logic [15:0] DEST_SIZE_RST  = 16'd2400;
  localparam logic        RETURN_ABS_RST = 1'b0;

  typedef enum logic [1:0] {
    OP_TAP_WR  = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_DRAIN   = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT  = 2'd0,
    CFG_DEST_SIZE  = 2'd1,
    CFG_RETURN_ABS = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                      op;
    logic [TIDX_W-1:0]        tap_index;
    logic signed [SAMP_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [IDX_W-1:0]        out_index;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // input word accepted this cycle
    logic mac_start;  // clear accumulator, latch index, reset tap counter
    logic issue;      // read one tap pair and advance
    logic out_load;   // move finished sum into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_push;    // offered word is a sample or drain
    logic hit;        // last push lands inside the destination
    logic last;       // tap counter is on the final tap
    logic busy;       // multiply pipeline still holds work
    logic out_free;   // output register can take a new word
  } status_t;

endpackage

### sv/scab_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scab_ctrl: sequencing controller
// Accepts one input word at a time, runs one multiply-accumulate per tap and
// hands the finished sum to the output register.
// ----------------------------------------------------------------------------
module scab_ctrl
  import scab_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && sts.is_push) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // push is done; see whether it yields a result
        if (sts.hit) begin
          cmd.mac_start = 1'b1;
          state_next    = ST_MAC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/scab_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scab_dp: convolution datapath
// Registers, tap memory, circular delay line, one multiplier with its
// accumulator, and the output register with absolute value and saturation.
// ----------------------------------------------------------------------------
module scab_dp
  import scab_pkg::*;
#(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_word_t              in_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = $clog2(MAX_TAPS + 1);
  localparam int CLOG  = $clog2(MAX_TAPS);
  localparam int ACC_W = (32 + CLOG > RES_W + 1) ? 32 + CLOG : RES_W + 1;
  localparam int DROP  = (SAMPLE_BITS < SAMP_W) ? SAMP_W - SAMPLE_BITS : 0;
  localparam logic [SAMP_W-1:0] SAMP_MASK = {SAMP_W{1'b1}} << DROP;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - RES_W + 1){1'b0}}, {(RES_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers
  logic [6:0]  tap_count;
  logic [15:0] dest_size;
  logic        return_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= TAP_COUNT_RST;
      dest_size  <= DEST_SIZE_RST;
      return_abs <= RETURN_ABS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TAP_COUNT:  tap_count  <= cfg_data[6:0];
        CFG_DEST_SIZE:  dest_size  <= cfg_data[15:0];
        CFG_RETURN_ABS: return_abs <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Taps in use, clamped to 1..MAX_TAPS
  logic [KW-1:0] t_use;
  logic [KW-1:0] half;

  always_comb begin
    if (tap_count == 7'd0) begin
      t_use = KW'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      t_use = KW'(MAX_TAPS);
    end else begin
      t_use = KW'(tap_count);
    end
    half = t_use >> 1;
  end

  // Input word decode
  logic                     is_tap_wr;
  logic                     is_push;
  logic                     is_restart;
  logic                     tap_in_range;
  logic signed [SAMP_W-1:0] val_masked;

  always_comb begin
    is_tap_wr    = (in_data.op == OP_TAP_WR);
    is_restart   = (in_data.op == OP_RESTART);
    is_push      = (in_data.op == OP_SAMPLE) || (in_data.op == OP_DRAIN);
    tap_in_range = (32'(in_data.tap_index) < MAX_TAPS);
    val_masked   = in_data.value & SAMP_MASK;
  end

  // Tap memory, undefined until written
  logic signed [SAMP_W-1:0] tap_mem [MAX_TAPS];
  logic signed [SAMP_W-1:0] tap_q;
  logic [KW-1:0]            k;

  always_ff @(posedge clk) begin
    if (cmd.take && is_tap_wr && tap_in_range) begin
      tap_mem[AW'(in_data.tap_index)] <= val_masked;
    end
    if (cmd.issue) begin
      tap_q <= tap_mem[k[AW-1:0]];
    end
  end

  // Circular delay line; entries at or beyond the push count read as zero
  logic signed [SAMP_W-1:0] dly_mem [DEPTH];
  logic signed [SAMP_W-1:0] dly_q;
  logic [AW-1:0]            wp;
  logic [CNT_W-1:0]         pushed;
  logic [AW-1:0]            wp_inc;

  assign wp_inc = wp + AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.take && is_push) begin
      dly_mem[wp_inc] <= (in_data.op == OP_SAMPLE) ? val_masked : '0;
    end
    if (cmd.issue) begin
      dly_q <= dly_mem[wp - k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      pushed <= '0;
    end else if (cmd.take && is_restart) begin
      pushed <= '0;
    end else if (cmd.take && is_push) begin
      wp <= wp_inc;
      if (pushed != {CNT_W{1'b1}}) begin
        pushed <= pushed + CNT_W'(1);
      end
    end
  end

  // Destination index of the latest push
  logic [CNT_W:0] diff;
  logic           hit;

  always_comb begin
    diff = {1'b0, pushed} - (CNT_W + 1)'(half) - (CNT_W + 1)'(1);
    hit  = !diff[CNT_W] && (diff[CNT_W-1:0] < {1'b0, dest_size});
  end

  // Tap counter
  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + KW'(1);
    end
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate
  logic                     v1, v2, live1;
  logic signed [2*SAMP_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [IDX_W-1:0]         idx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    live1 <= (CNT_W'(k) < pushed);
    // signed product; samples not yet pushed contribute zero
    if (live1) begin
      prod <= tap_q * dly_q;
    end else begin
      prod <= '0;
    end
    if (cmd.mac_start) begin
      acc   <= '0;
      idx_q <= diff[IDX_W-1:0];
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Absolute value, then saturation to the result range
  logic signed [ACC_W-1:0] acc_abs;
  logic signed [RES_W-1:0] res_sat;

  always_comb begin
    acc_abs = (return_abs && acc[ACC_W-1]) ? -acc : acc;
    if (acc_abs > SAT_HI) begin
      res_sat = SAT_HI[RES_W-1:0];
    end else if (acc_abs < SAT_LO) begin
      res_sat = SAT_LO[RES_W-1:0];
    end else begin
      res_sat = acc_abs[RES_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.result    <= res_sat;
      out_data.out_index <= idx_q;
    end
  end

  // Status
  always_comb begin
    sts.is_push  = is_push;
    sts.hit      = hit;
    sts.last     = (k == t_use - KW'(1));
    sts.busy     = v1 || v2;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

### sv/same_size_convolution_abs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// same_size_convolution_abs: same-aligned FIR convolution, optional abs
// A sample or drain word that lands inside the destination goes through
// accept, index check, one multiply-accumulate per tap through a single
// 16x16 multiplier fed by one read port on each of the tap and delay
// memories, pipeline drain and output load; one that does not goes through
// accept and index check only. The delay line is a circular memory with no
// clearing pass: entries beyond the pushed count read as zero. Registers
// (index 0 tap_count, 1 dest_size, 2 return_abs) are to be written only
// while the block is idle, which it does not enforce. cfg_ready is always
// high. A new word is taken while the previous result still waits on out.
// ----------------------------------------------------------------------------
module same_size_convolution_abs
  import scab_pkg::*;
#(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  scab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scab_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Output load only with a free output register and an empty pipeline
  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (sts.out_free && !sts.busy))
    else $error("result loaded while output full or pipeline busy");

  // A word is only taken with the multiply pipeline empty
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !sts.busy)
    else $error("word accepted while multiply pipeline busy");

  // A new result word only appears after a load command
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a load");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for same_size_convolution_abs
// Drives tap writes, samples, drains and restarts through the valid/ready
// input port with random gaps, configures the block between phases, and
// checks every output word against an in-bench FIR predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import scab_pkg::*;

  localparam int     NTAPS       = 64;
  localparam int     SAMPLE_BITS = 16;
  localparam int     ITEM_TARGET = 1100;
  localparam int     HOLD_CYCLES = 400;
  localparam int     SETTLE      = 100;   // outlasts the longest pass
  localparam int     COUNT_MAX   = (1 << CNT_W) - 1;
  localparam longint RES_MAX     = (longint'(1) <<< (RES_W - 1)) - 1;

  // Predictor of the same-aligned convolution plus queue of pending outputs
  class conv_checker;
    logic signed [SAMP_W-1:0] tap_mem[NTAPS];
    logic signed [SAMP_W-1:0] line[NTAPS];
    int unsigned              pushed;
    int unsigned              tap_count_reg;
    int unsigned              dest_size_reg;
    bit                       abs_reg;
    out_word_t                expected_outs[$];
    int                       errors;

    function new();
      foreach (tap_mem[k]) tap_mem[k] = '0;
      foreach (line[k]) line[k] = '0;
      pushed        = 0;
      tap_count_reg = TAP_COUNT_RST;
      dest_size_reg = DEST_SIZE_RST;
      abs_reg       = RETURN_ABS_RST;
      errors        = 0;
    endfunction

    function void note_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TAP_COUNT:  tap_count_reg = data[6:0];
        CFG_DEST_SIZE:  dest_size_reg = data;
        CFG_RETURN_ABS: abs_reg = data[0];
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted input word
    function void note_input(in_word_t w);
      int unsigned t;
      int unsigned half;
      int          k;
      longint      acc;
      out_word_t   o;
      case (w.op)
        OP_TAP_WR: tap_mem[w.tap_index] = w.value;
        OP_RESTART: begin
          foreach (line[j]) line[j] = '0;
          pushed = 0;
        end
        default: begin
          for (k = NTAPS - 1; k > 0; k--) line[k] = line[k-1];
          line[0] = (w.op == OP_SAMPLE) ? w.value : '0;
          if (pushed < COUNT_MAX) pushed++;
          t = (tap_count_reg == 0) ? 1 : (tap_count_reg > NTAPS ? NTAPS : tap_count_reg);
          half = t / 2;
          // only pushes landing inside [0, dest_size) produce a word
          if (pushed >= half + 1 && pushed - 1 - half < dest_size_reg) begin
            acc = 0;
            for (k = 0; k < t; k++) acc += longint'(tap_mem[k]) * longint'(line[k]);
            if (abs_reg && acc < 0) acc = -acc;
            if (acc > RES_MAX) acc = RES_MAX;
            else if (acc < -RES_MAX - 1) acc = -RES_MAX - 1;
            o.result    = acc[RES_W-1:0];
            o.out_index = IDX_W'(pushed - 1 - half);
            expected_outs.push_back(o);
          end
        end
      endcase
    endfunction

    function void note_fail(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_outs.size() == 0) begin
        note_fail($sformatf("unexpected word: result %0d index %0d",
                            got.result, got.out_index));
        return;
      end
      want = expected_outs.pop_front();
      if (got.result !== want.result || got.out_index !== want.out_index)
        note_fail($sformatf("mismatch: exp result %0d index %0d, got result %0d index %0d",
                            want.result, want.out_index, got.result, got.out_index));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  conv_checker board;
  int          items_sent;
  bit          steady;         // no idling on either side
  bit          hold_off_req;   // ask the output side for one long stall

  same_size_convolution_abs #(
    .MAX_TAPS   (NTAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  // Mostly random, with full-scale extremes and zero mixed in
  function automatic logic [SAMP_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  function automatic in_word_t make_word(op_t op, int idx, logic [SAMP_W-1:0] val);
    in_word_t w;
    w.op        = op;
    w.tap_index = TIDX_W'(idx);
    w.value     = val;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(w);
    items_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.note_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every pending word, then let trailing work finish
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_outs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Output side: random back-pressure plus one requested long hold-off
  initial begin : out_side
    int run;
    out_ready = 1'b0;
    run = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        run = 0;
      end
      if (run == 0) begin
        if (steady) begin
          out_ready <= 1'b1;
          run = 1;
        end else if ($urandom_range(0, 3) == 0) begin
          out_ready <= 1'b0;
          run = 1 + pick_gap();
        end else begin
          out_ready <= 1'b1;
          run = $urandom_range(1, 12);
        end
      end
      run--;
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  // Main stimulus
  initial begin : stim
    int unsigned tc;
    int unsigned eff;
    int unsigned dest;
    int          phase;
    int          nsamp;
    int          start;
    int          r;
    board        = new();
    items_sent   = 0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TAP_COUNT;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset config (one tap, abs off), extreme products
    send_word(make_word(OP_TAP_WR, 0, 16'h8000));
    send_word(make_word(OP_SAMPLE, 0, 16'h8000));
    send_word(make_word(OP_SAMPLE, 0, 16'h7fff));
    send_word(make_word(OP_SAMPLE, 0, 16'h0000));
    send_word(make_word(OP_DRAIN, 0, 16'h5a5a));
    send_word(make_word(OP_TAP_WR, 63, 16'h7fff));
    send_word(make_word(OP_RESTART, 0, 16'h1234));
    send_word(make_word(OP_SAMPLE, 0, 16'h0001));
    send_word(make_word(OP_TAP_WR, 1, 16'h7fff));
    send_word(make_word(OP_TAP_WR, 2, 16'h8000));
    wait_drained();

    // Three taps, short destination, abs on: edges of the output window
    write_reg(CFG_TAP_COUNT, 16'd3);
    write_reg(CFG_DEST_SIZE, 16'd3);
    write_reg(CFG_RETURN_ABS, 16'd1);
    write_reg(CFG_UNUSED, 16'hffff);
    send_word(make_word(OP_RESTART, 0, 16'h0000));
    send_word(make_word(OP_SAMPLE, 0, 16'h8000));
    send_word(make_word(OP_SAMPLE, 0, 16'h7fff));
    send_word(make_word(OP_SAMPLE, 0, 16'h0000));
    send_word(make_word(OP_DRAIN, 0, 16'h0000));
    send_word(make_word(OP_DRAIN, 0, 16'h0000));
    wait_drained();

    // Zero tap count acts as one; empty destination gives nothing
    write_reg(CFG_TAP_COUNT, 16'd0);
    write_reg(CFG_DEST_SIZE, 16'd0);
    send_word(make_word(OP_SAMPLE, 0, 16'h7fff));
    send_word(make_word(OP_DRAIN, 0, 16'h0000));

    // Load the full tap set so any tap count reads written taps only
    for (int i = 0; i < NTAPS; i++) send_word(make_word(OP_TAP_WR, i, rand_value()));
    wait_drained();

    // Random phases: config change, then restart/sample/drain runs
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: tc = 1;
        1: tc = NTAPS;
        2: tc = 0;
        3: tc = 127;
        4: tc = 2;
        default: tc = $urandom_range(3, NTAPS - 1);
      endcase
      case ($urandom_range(0, 9))
        0: dest = 0;
        1: dest = 1;
        2: dest = 16'hffff;
        default: dest = $urandom_range(2, 60);
      endcase
      if (phase == 0) begin
        tc = NTAPS;
        dest = 16'hffff;
      end else if (phase == 1) begin
        tc = 1;
        dest = 16'hffff;
      end
      write_reg(CFG_TAP_COUNT, CFG_DATA_W'(tc));
      write_reg(CFG_DEST_SIZE, CFG_DATA_W'(dest));
      write_reg(CFG_RETURN_ABS, (phase == 1) ? 16'd1 : CFG_DATA_W'($urandom_range(0, 1)));
      eff = (tc == 0) ? 1 : (tc > NTAPS ? NTAPS : tc);
      steady = (phase == 1) || (phase % 5 == 4);
      // fill the block while the output side is stalled
      if (phase == 1) hold_off_req = 1'b1;

      start = items_sent;
      while (items_sent - start < 70) begin
        if ($urandom_range(0, 5) != 0) send_word(make_word(OP_RESTART, 0, rand_value()));
        nsamp = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        repeat (nsamp) begin
          r = $urandom_range(0, 99);
          if (r < 92)
            send_word(make_word(OP_SAMPLE, $urandom_range(0, 63), rand_value()));
          else if (r < 95)
            send_word(make_word(OP_TAP_WR, $urandom_range(0, 63), rand_value()));
          else if (r < 98)
            send_word(make_word(OP_DRAIN, $urandom_range(0, 63), rand_value()));
          else
            send_word(make_word(OP_RESTART, $urandom_range(0, 63), rand_value()));
        end
        // flush the tail of the same-aligned window
        repeat (eff / 2 + $urandom_range(0, 2))
          send_word(make_word(OP_DRAIN, $urandom_range(0, 63), rand_value()));
      end
      wait_drained();
      phase++;
    end

    if (board.errors == 0 && board.expected_outs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(4ms);
    $display("TB_ERROR");
    $finish;
  end

endmodule
